>>> hw/rtl/crf_pkg.sv
// ----------------------------------------------------------------------------
// crf_pkg
// Shared types and constants for the clipped rectangle fill engine.
// ----------------------------------------------------------------------------
package crf_pkg;

  // Coordinate width of the latched rectangle and of the cursors.
  localparam int CW = 13;
  // Width of the pixel word.
  localparam int COLOUR_W = 32;
  // Width of the back buffer pixel offset.
  localparam int IDX_W = 25;
  // Input field width of positions and spans.
  localparam int POS_W = 16;
  // Configuration data width (widest register is the row pitch).
  localparam int CFG_DW = 14;
  localparam int CFG_AW = 2;
  // Depth of the queue between front and back (a power of two).
  localparam int QDEPTH = 4;

  // Command codes of the input word.
  typedef enum logic [1:0] {
    CMD_TICK    = 2'd0,
    CMD_ORIGIN  = 2'd1,
    CMD_CORNERS = 2'd2
  } crf_cmd_t;

  // Configuration register indexes.
  localparam logic [CFG_AW-1:0] REG_SCREEN_WIDTH  = 2'd0;
  localparam logic [CFG_AW-1:0] REG_SCREEN_HEIGHT = 2'd1;
  localparam logic [CFG_AW-1:0] REG_ROW_PITCH     = 2'd2;
  localparam logic [CFG_AW-1:0] REG_DISPLAY_READY = 2'd3;

  // Configuration reset values.
  localparam logic [CW-1:0]     RST_SCREEN_WIDTH  = 13'd640;
  localparam logic [CW-1:0]     RST_SCREEN_HEIGHT = 13'd480;
  localparam logic [CFG_DW-1:0] RST_ROW_PITCH     = 14'd640;

  // One classified word: either a tick or a clipped, non-empty start.
  typedef struct packed {
    logic                is_tick;
    logic [CW-1:0]       x0;
    logic [CW-1:0]       y0;
    logic [CW-1:0]       x1;
    logic [CW-1:0]       y1;
    logic [COLOUR_W-1:0] colour;
  } crf_item_t;

endpackage

>>> hw/rtl/crf_front.sv
// ----------------------------------------------------------------------------
// crf_front
// Accepts input words, clips start commands to the screen and drops the
// words that can never have an effect.
// ----------------------------------------------------------------------------
module crf_front #(
  parameter int MAX_DIM = 4096
) (
  input  logic                          in_valid,
  input  logic                          q_full,
  input  logic [1:0]                    in_cmd,
  input  logic signed [crf_pkg::POS_W-1:0] in_pos_x,
  input  logic signed [crf_pkg::POS_W-1:0] in_pos_y,
  input  logic signed [crf_pkg::POS_W-1:0] in_span_x,
  input  logic signed [crf_pkg::POS_W-1:0] in_span_y,
  input  logic [crf_pkg::COLOUR_W-1:0]  in_fill_colour,
  input  logic [crf_pkg::CW-1:0]        cfg_screen_width,
  input  logic [crf_pkg::CW-1:0]        cfg_screen_height,
  input  logic                          cfg_display_ready,
  output logic                          push,
  output crf_pkg::crf_item_t            push_item
);
  import crf_pkg::*;

  localparam logic [CW:0] DIM_CAP = (CW+1)'(MAX_DIM);

  logic [CW:0]          w_eff, h_eff;
  logic signed [POS_W:0] w_s, h_s;
  logic signed [POS_W:0] px, py, sx, sy;
  logic signed [POS_W:0] sum_x, sum_y, ex, ey;
  logic                 origin_ok, origin_empty;
  logic signed [POS_W:0] lo_x, hi_x, lo_y, hi_y;
  logic signed [POS_W:0] cx0, cx1, cy0, cy1;
  logic                 corner_empty;
  logic                 keep;

  // Screen size saturated to the largest supported dimension.
  assign w_eff = ({1'b0, cfg_screen_width} > DIM_CAP) ? DIM_CAP : {1'b0, cfg_screen_width};
  assign h_eff = ({1'b0, cfg_screen_height} > DIM_CAP) ? DIM_CAP : {1'b0, cfg_screen_height};
  assign w_s   = signed'({{(POS_W-CW){1'b0}}, w_eff});
  assign h_s   = signed'({{(POS_W-CW){1'b0}}, h_eff});

  assign px = {in_pos_x[POS_W-1], in_pos_x};
  assign py = {in_pos_y[POS_W-1], in_pos_y};
  assign sx = {in_span_x[POS_W-1], in_span_x};
  assign sy = {in_span_y[POS_W-1], in_span_y};

  // Start by origin and size: origin must lie on screen, a negative or
  // overlong size reaches the screen edge.
  always_comb begin
    origin_ok    = (px >= 0) && (py >= 0) && (px < w_s) && (py < h_s);
    sum_x        = px + sx;
    sum_y        = py + sy;
    ex           = ((sx < 0) || (sum_x > w_s)) ? w_s : sum_x;
    ey           = ((sy < 0) || (sum_y > h_s)) ? h_s : sum_y;
    origin_empty = !((px < ex) && (py < ey));
  end

  // Start by corners: order the corners, then clamp them to the screen.
  always_comb begin
    lo_x = (px > sx) ? sx : px;
    hi_x = (px > sx) ? px : sx;
    lo_y = (py > sy) ? sy : py;
    hi_y = (py > sy) ? py : sy;
    cx0  = (lo_x < 0) ? '0 : lo_x;
    cy0  = (lo_y < 0) ? '0 : lo_y;
    cx1  = (hi_x > w_s) ? w_s : hi_x;
    cy1  = (hi_y > h_s) ? h_s : hi_y;
    corner_empty = !((cx0 < cx1) && (cy0 < cy1));
  end

  // Classification and the word handed to the queue.
  always_comb begin
    push_item        = '0;
    push_item.colour = in_fill_colour;
    keep             = 1'b0;
    case (in_cmd)
      CMD_TICK: begin
        keep              = 1'b1;
        push_item.is_tick = 1'b1;
      end
      CMD_ORIGIN: begin
        keep         = cfg_display_ready && origin_ok && !origin_empty;
        push_item.x0 = px[CW-1:0];
        push_item.y0 = py[CW-1:0];
        push_item.x1 = ex[CW-1:0];
        push_item.y1 = ey[CW-1:0];
      end
      CMD_CORNERS: begin
        keep         = cfg_display_ready && !corner_empty;
        push_item.x0 = cx0[CW-1:0];
        push_item.y0 = cy0[CW-1:0];
        push_item.x1 = cx1[CW-1:0];
        push_item.y1 = cy1[CW-1:0];
      end
      default: begin
        keep = 1'b0;
      end
    endcase
  end

  assign push = in_valid && !q_full && keep;

endmodule

>>> hw/rtl/crf_queue.sv
// ----------------------------------------------------------------------------
// crf_queue
// Short register queue that decouples the classifying front from the
// executing back.
// ----------------------------------------------------------------------------
module crf_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  crf_pkg::crf_item_t push_item,
  input  logic               pop,
  output logic               full,
  output logic               head_valid,
  output crf_pkg::crf_item_t head_item
);
  import crf_pkg::*;

  localparam int QAW = $clog2(QDEPTH);

  crf_item_t        slots_r [QDEPTH];
  logic [QAW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [QAW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [QAW:0]     count_r, count_nxt;

  // Pointer and fill count bookkeeping.
  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r + (QAW+1)'(push) - (QAW+1)'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Slot storage.
  always_ff @(posedge clk) begin
    if (push) begin
      slots_r[wr_ptr_r] <= push_item;
    end
  end

  assign full       = (count_r == (QAW+1)'(QDEPTH));
  assign head_valid = (count_r != '0);
  assign head_item  = slots_r[rd_ptr_r];

endmodule

>>> hw/rtl/crf_back.sv
// ----------------------------------------------------------------------------
// crf_back
// Executes queued words: latches rectangles, walks the cursor in row-major
// order on ticks and holds each pixel write in an output register.
// ----------------------------------------------------------------------------
module crf_back #(
  parameter int MAX_PITCH = 8192
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           head_valid,
  input  crf_pkg::crf_item_t             head_item,
  output logic                           pop,
  input  logic [crf_pkg::CFG_DW-1:0]     cfg_row_pitch,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [crf_pkg::IDX_W-1:0]      out_pixel_index,
  output logic [crf_pkg::COLOUR_W-1:0]   out_pixel_value,
  output logic                           out_last_pixel
);
  import crf_pkg::*;

  localparam int PROD_W = CW + CFG_DW;
  localparam logic [CFG_DW:0] PITCH_CAP = (CFG_DW+1)'(MAX_PITCH);

  logic                busy_r, busy_nxt;
  logic [CW-1:0]       cursor_x_r, cursor_x_nxt;
  logic [CW-1:0]       cursor_y_r, cursor_y_nxt;
  logic [CW-1:0]       row_first_x_r, row_first_x_nxt;
  logic [CW-1:0]       row_end_x_r, row_end_x_nxt;
  logic [CW-1:0]       rect_end_y_r, rect_end_y_nxt;
  logic [COLOUR_W-1:0] colour_r, colour_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [IDX_W-1:0]    out_index_r, out_index_nxt;
  logic [COLOUR_W-1:0] out_value_r, out_value_nxt;
  logic                out_last_r, out_last_nxt;

  logic [CFG_DW-1:0]   pitch_eff;
  logic [PROD_W-1:0]   row_base;
  logic [PROD_W-1:0]   pixel_sum;
  logic [CW-1:0]       x_inc;
  logic [CW-1:0]       y_inc;
  logic                last;
  logic                emit;
  logic                out_free;

  // Pixel offset of the cursor: one multiply and one add.
  always_comb begin
    pitch_eff = ({1'b0, cfg_row_pitch} > PITCH_CAP) ? PITCH_CAP[CFG_DW-1:0] : cfg_row_pitch;
    row_base  = PROD_W'(cursor_y_r) * PROD_W'(pitch_eff);
    pixel_sum = row_base + PROD_W'(cursor_x_r);
  end

  // End-of-rectangle test and cursor increments.
  always_comb begin
    x_inc = cursor_x_r + 1'b1;
    y_inc = cursor_y_r + 1'b1;
    last  = (({1'b0, cursor_x_r} + 1'b1) >= {1'b0, row_end_x_r}) &&
            (({1'b0, cursor_y_r} + 1'b1) >= {1'b0, rect_end_y_r});
  end

  // A tick emits only while a fill runs; it waits for a free output slot.
  assign emit     = head_item.is_tick && busy_r;
  assign out_free = !out_valid_r || !out_stall;
  assign pop      = head_valid && (!emit || out_free);

  // Next state of the engine and of the output register.
  always_comb begin
    busy_nxt        = busy_r;
    cursor_x_nxt    = cursor_x_r;
    cursor_y_nxt    = cursor_y_r;
    row_first_x_nxt = row_first_x_r;
    row_end_x_nxt   = row_end_x_r;
    rect_end_y_nxt  = rect_end_y_r;
    colour_nxt      = colour_r;
    out_valid_nxt   = out_free ? 1'b0 : out_valid_r;
    out_index_nxt   = out_index_r;
    out_value_nxt   = out_value_r;
    out_last_nxt    = out_last_r;
    if (pop) begin
      if (head_item.is_tick) begin
        if (busy_r) begin
          out_valid_nxt = 1'b1;
          out_index_nxt = pixel_sum[IDX_W-1:0];
          out_value_nxt = colour_r;
          out_last_nxt  = last;
          if (x_inc >= row_end_x_r) begin
            cursor_x_nxt = row_first_x_r;
            cursor_y_nxt = y_inc;
          end else begin
            cursor_x_nxt = x_inc;
          end
          if (last) begin
            busy_nxt = 1'b0;
          end
        end
      end else if (!busy_r) begin
        busy_nxt        = 1'b1;
        cursor_x_nxt    = head_item.x0;
        cursor_y_nxt    = head_item.y0;
        row_first_x_nxt = head_item.x0;
        row_end_x_nxt   = head_item.x1;
        rect_end_y_nxt  = head_item.y1;
        colour_nxt      = head_item.colour;
      end
    end
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      busy_r      <= busy_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Rectangle, cursor and output payload.
  always_ff @(posedge clk) begin
    cursor_x_r    <= cursor_x_nxt;
    cursor_y_r    <= cursor_y_nxt;
    row_first_x_r <= row_first_x_nxt;
    row_end_x_r   <= row_end_x_nxt;
    rect_end_y_r  <= rect_end_y_nxt;
    colour_r      <= colour_nxt;
    out_index_r   <= out_index_nxt;
    out_value_r   <= out_value_nxt;
    out_last_r    <= out_last_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_pixel_index = out_index_r;
  assign out_pixel_value = out_value_r;
  assign out_last_pixel  = out_last_r;

`ifndef SYNTHESIS
  // While a fill runs the cursor stays inside the latched rectangle.
  a_cursor_inside: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> (cursor_x_r < row_end_x_r) && (cursor_y_r < rect_end_y_r) &&
               (row_first_x_r <= cursor_x_r))
    else $error("cursor left the latched rectangle");

  // The final pixel of a rectangle ends the fill.
  a_last_ends_fill: assert property (@(posedge clk) disable iff (!rst_n)
    (pop && emit && last) |=> !busy_r)
    else $error("engine still busy after final pixel");

  // A pixel write is only produced by a tick during a fill.
  a_emit_source: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !$past(out_valid_r)) |-> $past(pop && emit))
    else $error("pixel write appeared without a tick during a fill");
`endif

endmodule

>>> hw/rtl/clipped_rectangle_fill.sv
// ----------------------------------------------------------------------------
// clipped_rectangle_fill
// Rectangle fill engine with screen clipping: start commands latch a clipped
// rectangle while idle, each tick during a fill emits one pixel write in
// row-major order through a queue slot and then the output register.
// Throughput: one word per cycle while in_stall and out_stall are low; the
// cursor-times-pitch multiply and add into the output register is the
// longest path at this rate.
// Reset: registers return to 640x480, pitch 640, display not ready; the queue
// empties and the engine goes idle.
// ----------------------------------------------------------------------------
module clipped_rectangle_fill #(
  parameter int MAX_DIM   = 4096,
  parameter int MAX_PITCH = 8192
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [crf_pkg::CFG_AW-1:0]       cfg_index,
  input  logic [crf_pkg::CFG_DW-1:0]       cfg_wdata,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [1:0]                       in_cmd,
  input  logic signed [crf_pkg::POS_W-1:0] in_pos_x,
  input  logic signed [crf_pkg::POS_W-1:0] in_pos_y,
  input  logic signed [crf_pkg::POS_W-1:0] in_span_x,
  input  logic signed [crf_pkg::POS_W-1:0] in_span_y,
  input  logic [crf_pkg::COLOUR_W-1:0]     in_fill_colour,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [crf_pkg::IDX_W-1:0]        out_pixel_index,
  output logic [crf_pkg::COLOUR_W-1:0]     out_pixel_value,
  output logic                             out_last_pixel
);
  import crf_pkg::*;

  logic [CW-1:0]     screen_width_r;
  logic [CW-1:0]     screen_height_r;
  logic [CFG_DW-1:0] row_pitch_r;
  logic              display_ready_r;

  logic      q_full;
  logic      push;
  crf_item_t push_item;
  logic      pop;
  logic      head_valid;
  crf_item_t head_item;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      screen_width_r  <= RST_SCREEN_WIDTH;
      screen_height_r <= RST_SCREEN_HEIGHT;
      row_pitch_r     <= RST_ROW_PITCH;
      display_ready_r <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_SCREEN_WIDTH:  screen_width_r  <= cfg_wdata[CW-1:0];
        REG_SCREEN_HEIGHT: screen_height_r <= cfg_wdata[CW-1:0];
        REG_ROW_PITCH:     row_pitch_r     <= cfg_wdata;
        REG_DISPLAY_READY: display_ready_r <= cfg_wdata[0];
        default: begin
        end
      endcase
    end
  end

  assign in_stall = q_full;

  crf_front #(
    .MAX_DIM (MAX_DIM)
  ) u_front (
    .in_valid          (in_valid),
    .q_full            (q_full),
    .in_cmd            (in_cmd),
    .in_pos_x          (in_pos_x),
    .in_pos_y          (in_pos_y),
    .in_span_x         (in_span_x),
    .in_span_y         (in_span_y),
    .in_fill_colour    (in_fill_colour),
    .cfg_screen_width  (screen_width_r),
    .cfg_screen_height (screen_height_r),
    .cfg_display_ready (display_ready_r),
    .push              (push),
    .push_item         (push_item)
  );

  crf_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_item  (push_item),
    .pop        (pop),
    .full       (q_full),
    .head_valid (head_valid),
    .head_item  (head_item)
  );

  crf_back #(
    .MAX_PITCH (MAX_PITCH)
  ) u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .head_valid      (head_valid),
    .head_item       (head_item),
    .pop             (pop),
    .cfg_row_pitch   (row_pitch_r),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_pixel_index (out_pixel_index),
    .out_pixel_value (out_pixel_value),
    .out_last_pixel  (out_last_pixel)
  );

endmodule
